// ===== rtl/core/sd_card_init_sequencer_unit_assert.svh =====
// ----------------------------------------------------------------------------
// sd card init sequencer assertion macros
// clocked implication checks used by the checker module
// ----------------------------------------------------------------------------
`ifndef SD_CARD_INIT_SEQUENCER_UNIT_ASSERT_SVH
`define SD_CARD_INIT_SEQUENCER_UNIT_ASSERT_SVH

// same-cycle implication
`define SDI_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sdinit assertion failed");

// next-cycle implication
`define SDI_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sdinit assertion failed");

`endif

// ===== rtl/core/sdinit_pkg.sv =====
// ----------------------------------------------------------------------------
// sd card init sequencer package
// phase encoding, request kinds, response types and command constants
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sdinit_pkg;

   typedef enum logic [3:0] {
      PH_IDLE   = 4'd0,
      PH_CMD0   = 4'd1,
      PH_CMD8   = 4'd2,
      PH_CMD55  = 4'd3,
      PH_ACMD41 = 4'd4,
      PH_CMD2   = 4'd5,
      PH_CMD3   = 4'd6,
      PH_CMD9   = 4'd7,
      PH_CMD7   = 4'd8,
      PH_CMD16  = 4'd9,
      PH_READY  = 4'd10,
      PH_RW     = 4'd11,
      PH_SHUT   = 4'd12,
      PH_FAILED = 4'd13
   } phase_type;

   localparam logic [2:0] KIND_START    = 3'd0;
   localparam logic [2:0] KIND_RESPONSE = 3'd1;
   localparam logic [2:0] KIND_READ     = 3'd2;
   localparam logic [2:0] KIND_WRITE    = 3'd3;
   localparam logic [2:0] KIND_SHUTDOWN = 3'd4;

   localparam logic [2:0] RT_NONE = 3'd0;
   localparam logic [2:0] RT_R1   = 3'd1;
   localparam logic [2:0] RT_R1B  = 3'd2;
   localparam logic [2:0] RT_R2   = 3'd3;
   localparam logic [2:0] RT_R3   = 3'd4;
   localparam logic [2:0] RT_R6   = 3'd5;
   localparam logic [2:0] RT_R7   = 3'd6;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_INIT   = 2'd1;
   localparam logic [1:0] ST_READY  = 2'd2;
   localparam logic [1:0] ST_FAILED = 2'd3;

   localparam logic [5:0] CMD_GO_IDLE      = 6'd0;
   localparam logic [5:0] CMD_SEND_CSD     = 6'd9;
   localparam logic [5:0] CMD_ALL_SEND_CID = 6'd2;
   localparam logic [5:0] CMD_SEND_RCA     = 6'd3;
   localparam logic [5:0] CMD_SELECT       = 6'd7;
   localparam logic [5:0] CMD_SEND_IF_COND = 6'd8;
   localparam logic [5:0] CMD_GO_INACTIVE  = 6'd15;
   localparam logic [5:0] CMD_SET_BLOCKLEN = 6'd16;
   localparam logic [5:0] CMD_READ_SINGLE  = 6'd17;
   localparam logic [5:0] CMD_WRITE_SINGLE = 6'd24;
   localparam logic [5:0] CMD_SD_SEND_OP   = 6'd41;
   localparam logic [5:0] CMD_APP          = 6'd55;

   localparam logic [31:0] IF_COND_ARG   = 32'h0000_01AA;
   localparam logic [7:0]  IF_COND_ECHO  = 8'hAA;
   localparam logic [31:0] OCR_HCS       = 32'h4000_0000;
   localparam logic [31:0] OCR_VDD_WIN   = 32'h0010_0000;
   localparam logic [31:0] BLOCK_LEN_ARG = 32'd512;

   localparam logic [21:0] WAIT_CMD0    = 22'h01_0000;
   localparam logic [21:0] WAIT_CMD8    = 22'h10_0000;
   localparam logic [21:0] WAIT_RETRY   = 22'h20_0000;

   localparam logic [7:0]  RETRY_RESET  = 8'd25;
   localparam logic [15:0] RCA_RESET    = 16'd1;

   function automatic logic [1:0] status_of(input phase_type ph);
      logic [1:0] st;
      unique case (ph)
         PH_IDLE:                      st = ST_IDLE;
         PH_FAILED:                    st = ST_FAILED;
         PH_READY, PH_RW, PH_SHUT:     st = ST_READY;
         default:                      st = ST_INIT;
      endcase
      return st;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/sd_card_init_sequencer_unit.sv =====
// ----------------------------------------------------------------------------
// sd card init sequencer
// host-side command sequencer for sd card start-up, block reads and writes
// ----------------------------------------------------------------------------
// Each request (start, command response, read, write, shutdown) yields one
// result in the cycle after it is taken: the next command to send with its
// argument, response type and pre-delay, plus the card status. A request
// is taken every cycle while the result register is free or being drained
// on the same edge; req_stall is high only while a result waits under
// rsp_stall. The single pass to the result register gives one request per
// cycle while req_stall is low. retry_limit is written through csr_wr_en /
// csr_wr_data by the user only while idle; the block does not enforce this.
`timescale 1ns / 1ps
`default_nettype none

module sd_card_init_sequencer_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_wr_en,
   input  wire logic [7:0]  csr_wr_data,
   input  wire logic        req_valid,
   output      logic        req_stall,
   input  wire logic [2:0]  req_kind,
   input  wire logic        req_cmd_error,
   input  wire logic [31:0] req_resp_word0,
   input  wire logic [31:0] req_resp_word1,
   input  wire logic [31:0] req_resp_word2,
   input  wire logic [31:0] req_resp_word3,
   input  wire logic [31:0] req_block_number,
   output      logic        rsp_valid,
   input  wire logic        rsp_stall,
   output      logic        rsp_issue,
   output      logic [5:0]  rsp_cmd_index,
   output      logic [31:0] rsp_cmd_arg,
   output      logic [2:0]  rsp_resp_type,
   output      logic        rsp_has_data,
   output      logic        rsp_is_write,
   output      logic [21:0] rsp_wait_ticks,
   output      logic [1:0]  rsp_status,
   output      logic        rsp_command_failed,
   output      logic        rsp_card_v2,
   output      logic [15:0] rsp_card_address
);

   sdinit_pkg::phase_type phase_ff, phase_in;
   logic [7:0]  retry_limit_ff;
   logic [7:0]  attempt_ff, attempt_in;
   logic        v2_ff, v2_in;
   logic [15:0] rca_ff, rca_in;

   logic        load;
   logic        rsp_valid_ff, rsp_valid_in;
   logic        issue_ff, issue_in;
   logic [5:0]  cmd_index_ff, cmd_index_in;
   logic [31:0] cmd_arg_ff, cmd_arg_in;
   logic [2:0]  resp_type_ff, resp_type_in;
   logic        has_data_ff, has_data_in;
   logic        is_write_ff, is_write_in;
   logic [21:0] wait_ticks_ff, wait_ticks_in;
   logic        failed_ff, failed_in;

   logic [7:0]  attempt_inc;
   logic [31:0] rca_arg;
   logic [31:0] block_arg;

   // resp_word1..3 carry the cid/csd words, which this block does not keep
   assign req_stall = rsp_valid_ff & rsp_stall;
   assign load      = req_valid & ~req_stall;

   assign attempt_inc = attempt_ff + 8'd1;
   assign rca_arg     = {rca_ff, 16'h0000};
   assign block_arg   = v2_ff ? req_block_number : {req_block_number[22:0], 9'b0};

   always_comb begin
      phase_in      = phase_ff;
      attempt_in    = attempt_ff;
      v2_in         = v2_ff;
      rca_in        = rca_ff;
      issue_in      = 1'b0;
      cmd_index_in  = 6'd0;
      cmd_arg_in    = 32'd0;
      resp_type_in  = sdinit_pkg::RT_NONE;
      has_data_in   = 1'b0;
      is_write_in   = 1'b0;
      wait_ticks_in = 22'd0;
      failed_in     = 1'b0;

      unique case (req_kind)
         sdinit_pkg::KIND_START: begin
            v2_in         = 1'b0;
            attempt_in    = 8'd0;
            rca_in        = sdinit_pkg::RCA_RESET;
            issue_in      = 1'b1;
            cmd_index_in  = sdinit_pkg::CMD_GO_IDLE;
            wait_ticks_in = sdinit_pkg::WAIT_CMD0;
            phase_in      = sdinit_pkg::PH_CMD0;
         end
         sdinit_pkg::KIND_RESPONSE: begin
            unique case (phase_ff)
               sdinit_pkg::PH_CMD0: begin
                  if (req_cmd_error) begin
                     phase_in = sdinit_pkg::PH_FAILED;
                  end else begin
                     issue_in      = 1'b1;
                     cmd_index_in  = sdinit_pkg::CMD_SEND_IF_COND;
                     cmd_arg_in    = sdinit_pkg::IF_COND_ARG;
                     resp_type_in  = sdinit_pkg::RT_R7;
                     wait_ticks_in = sdinit_pkg::WAIT_CMD8;
                     phase_in      = sdinit_pkg::PH_CMD8;
                  end
               end
               sdinit_pkg::PH_CMD8: begin
                  if (!req_cmd_error && req_resp_word0[7:0] == sdinit_pkg::IF_COND_ECHO) begin
                     v2_in = 1'b1;
                  end
                  attempt_in   = 8'd0;
                  issue_in     = 1'b1;
                  cmd_index_in = sdinit_pkg::CMD_APP;
                  resp_type_in = sdinit_pkg::RT_R1;
                  phase_in     = sdinit_pkg::PH_CMD55;
               end
               sdinit_pkg::PH_CMD55: begin
                  issue_in     = 1'b1;
                  cmd_index_in = sdinit_pkg::CMD_SD_SEND_OP;
                  cmd_arg_in   = (v2_ff ? sdinit_pkg::OCR_HCS : 32'd0)
                                 | sdinit_pkg::OCR_VDD_WIN;
                  resp_type_in = sdinit_pkg::RT_R3;
                  phase_in     = sdinit_pkg::PH_ACMD41;
               end
               sdinit_pkg::PH_ACMD41: begin
                  if (req_resp_word0[31]) begin
                     issue_in     = 1'b1;
                     cmd_index_in = sdinit_pkg::CMD_ALL_SEND_CID;
                     resp_type_in = sdinit_pkg::RT_R2;
                     phase_in     = sdinit_pkg::PH_CMD2;
                  end else begin
                     attempt_in = attempt_inc;
                     // a limit of zero fails on the first miss
                     if (attempt_inc >= retry_limit_ff || attempt_inc == 8'd0) begin
                        phase_in = sdinit_pkg::PH_FAILED;
                     end else begin
                        issue_in      = 1'b1;
                        cmd_index_in  = sdinit_pkg::CMD_APP;
                        resp_type_in  = sdinit_pkg::RT_R1;
                        wait_ticks_in = sdinit_pkg::WAIT_RETRY;
                        phase_in      = sdinit_pkg::PH_CMD55;
                     end
                  end
               end
               sdinit_pkg::PH_CMD2: begin
                  if (req_cmd_error) begin
                     phase_in = sdinit_pkg::PH_FAILED;
                  end else begin
                     issue_in     = 1'b1;
                     cmd_index_in = sdinit_pkg::CMD_SEND_RCA;
                     cmd_arg_in   = rca_arg;
                     resp_type_in = sdinit_pkg::RT_R6;
                     phase_in     = sdinit_pkg::PH_CMD3;
                  end
               end
               sdinit_pkg::PH_CMD3: begin
                  if (req_cmd_error) begin
                     phase_in = sdinit_pkg::PH_FAILED;
                  end else begin
                     rca_in       = req_resp_word0[31:16];
                     issue_in     = 1'b1;
                     cmd_index_in = sdinit_pkg::CMD_SEND_CSD;
                     cmd_arg_in   = {req_resp_word0[31:16], 16'h0000};
                     resp_type_in = sdinit_pkg::RT_R2;
                     phase_in     = sdinit_pkg::PH_CMD9;
                  end
               end
               sdinit_pkg::PH_CMD9: begin
                  if (req_cmd_error) begin
                     phase_in = sdinit_pkg::PH_FAILED;
                  end else begin
                     issue_in     = 1'b1;
                     cmd_index_in = sdinit_pkg::CMD_SELECT;
                     cmd_arg_in   = rca_arg;
                     resp_type_in = sdinit_pkg::RT_R1B;
                     phase_in     = sdinit_pkg::PH_CMD7;
                  end
               end
               sdinit_pkg::PH_CMD7: begin
                  if (req_cmd_error) begin
                     phase_in = sdinit_pkg::PH_FAILED;
                  end else begin
                     issue_in     = 1'b1;
                     cmd_index_in = sdinit_pkg::CMD_SET_BLOCKLEN;
                     cmd_arg_in   = sdinit_pkg::BLOCK_LEN_ARG;
                     resp_type_in = sdinit_pkg::RT_R1;
                     phase_in     = sdinit_pkg::PH_CMD16;
                  end
               end
               sdinit_pkg::PH_CMD16: begin
                  phase_in = req_cmd_error ? sdinit_pkg::PH_FAILED : sdinit_pkg::PH_READY;
               end
               sdinit_pkg::PH_RW: begin
                  failed_in = req_cmd_error;
                  phase_in  = sdinit_pkg::PH_READY;
               end
               sdinit_pkg::PH_SHUT: begin
                  failed_in = req_cmd_error;
                  phase_in  = req_cmd_error ? sdinit_pkg::PH_READY : sdinit_pkg::PH_IDLE;
               end
               default: begin
                  // nothing outstanding, response dropped
               end
            endcase
         end
         sdinit_pkg::KIND_READ, sdinit_pkg::KIND_WRITE: begin
            if (phase_ff == sdinit_pkg::PH_READY) begin
               issue_in     = 1'b1;
               is_write_in  = (req_kind == sdinit_pkg::KIND_WRITE);
               cmd_index_in = (req_kind == sdinit_pkg::KIND_WRITE)
                              ? sdinit_pkg::CMD_WRITE_SINGLE
                              : sdinit_pkg::CMD_READ_SINGLE;
               cmd_arg_in   = block_arg;
               resp_type_in = sdinit_pkg::RT_R1;
               has_data_in  = 1'b1;
               phase_in     = sdinit_pkg::PH_RW;
            end
         end
         sdinit_pkg::KIND_SHUTDOWN: begin
            if (phase_ff == sdinit_pkg::PH_READY) begin
               issue_in     = 1'b1;
               cmd_index_in = sdinit_pkg::CMD_GO_INACTIVE;
               cmd_arg_in   = rca_arg;
               phase_in     = sdinit_pkg::PH_SHUT;
            end
         end
         default: begin
            // unused kinds leave the state alone
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= sdinit_pkg::PH_IDLE;
         attempt_ff     <= 8'd0;
         v2_ff          <= 1'b0;
         rca_ff         <= sdinit_pkg::RCA_RESET;
         retry_limit_ff <= sdinit_pkg::RETRY_RESET;
         rsp_valid_ff   <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            retry_limit_ff <= csr_wr_data;
         end
         if (load) begin
            phase_ff   <= phase_in;
            attempt_ff <= attempt_in;
            v2_ff      <= v2_in;
            rca_ff     <= rca_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         issue_ff      <= issue_in;
         cmd_index_ff  <= cmd_index_in;
         cmd_arg_ff    <= cmd_arg_in;
         resp_type_ff  <= resp_type_in;
         has_data_ff   <= has_data_in;
         is_write_ff   <= is_write_in;
         wait_ticks_ff <= wait_ticks_in;
         failed_ff     <= failed_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_issue          = issue_ff;
   assign rsp_cmd_index      = cmd_index_ff;
   assign rsp_cmd_arg        = cmd_arg_ff;
   assign rsp_resp_type      = resp_type_ff;
   assign rsp_has_data       = has_data_ff;
   assign rsp_is_write       = is_write_ff;
   assign rsp_wait_ticks     = wait_ticks_ff;
   assign rsp_status         = sdinit_pkg::status_of(phase_ff);
   assign rsp_command_failed = failed_ff;
   assign rsp_card_v2        = v2_ff;
   assign rsp_card_address   = rca_ff;

endmodule

`default_nettype wire

// ===== rtl/core/sdinit_checker.sv =====
// ----------------------------------------------------------------------------
// sd card init sequencer checker
// port-level checks on the result channel and request back-pressure
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "sd_card_init_sequencer_unit_assert.svh"

module sdinit_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_stall,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic        rsp_issue,
   input wire logic [5:0]  rsp_cmd_index,
   input wire logic [31:0] rsp_cmd_arg,
   input wire logic        rsp_has_data,
   input wire logic        rsp_is_write,
   input wire logic [21:0] rsp_wait_ticks,
   input wire logic [1:0]  rsp_status,
   input wire logic        rsp_command_failed
);

   logic quiet_ok;
   logic data_ok;
   logic failed_ok;

   assign quiet_ok  = rsp_cmd_index == 6'd0 && rsp_cmd_arg == 32'd0
                      && rsp_wait_ticks == 22'd0 && !rsp_has_data && !rsp_is_write;
   assign data_ok   = rsp_issue
                      && (rsp_cmd_index == sdinit_pkg::CMD_READ_SINGLE
                          || rsp_cmd_index == sdinit_pkg::CMD_WRITE_SINGLE)
                      && rsp_is_write == (rsp_cmd_index == sdinit_pkg::CMD_WRITE_SINGLE);
   assign failed_ok = rsp_status == sdinit_pkg::ST_READY && !rsp_issue;

   // a stalled result stays offered
   `SDI_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid)

   // requests are held back only by a result waiting downstream
   `SDI_ASSERT_IMPLY(a_req_stall_cause, clock, reset, req_stall, rsp_valid && rsp_stall)

   // no command means an all-zero command
   `SDI_ASSERT_IMPLY(a_quiet_fields, clock, reset, rsp_valid && !rsp_issue, quiet_ok)

   // data commands are single block reads or writes
   `SDI_ASSERT_IMPLY(a_data_cmd, clock, reset, rsp_valid && rsp_has_data, data_ok)

   // a failed command is reported only from the ready state
   `SDI_ASSERT_IMPLY(a_failed_ready, clock, reset, rsp_valid && rsp_command_failed, failed_ok)

endmodule

bind sd_card_init_sequencer_unit sdinit_checker u_sdinit_checker (
   .clock              (clock),
   .reset              (reset),
   .req_stall          (req_stall),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_issue          (rsp_issue),
   .rsp_cmd_index      (rsp_cmd_index),
   .rsp_cmd_arg        (rsp_cmd_arg),
   .rsp_has_data       (rsp_has_data),
   .rsp_is_write       (rsp_is_write),
   .rsp_wait_ticks     (rsp_wait_ticks),
   .rsp_status         (rsp_status),
   .rsp_command_failed (rsp_command_failed)
);

`default_nettype wire
